>>> rtl/cmase_pkg.sv
package cmase_pkg;

    localparam int DEF_MAX_WINDOW  = 31;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int FRAC_BITS       = 8;
    localparam int CFG_W           = 5;

    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 5'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIVGO,
        ST_DIVWAIT,
        ST_EMIT,
        ST_TRIM
    } back_state_t;

endpackage

>>> rtl/cmase_ifs.sv
interface cmase_in_if
    import cmase_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] range_sample;
    logic                   scan_end;

    modport source (output valid, output range_sample, output scan_end, input ready);
    modport sink (input valid, input range_sample, input scan_end, output ready);
endinterface

interface cmase_out_if
    import cmase_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                             valid;
    logic                             ready;
    logic [SAMPLE_BITS+FRAC_BITS-1:0] smoothed_value;
    logic                             result_last;

    modport source (output valid, output smoothed_value, output result_last, input ready);
    modport sink (input valid, input smoothed_value, input result_last, output ready);
endinterface

interface cmase_job_if
    import cmase_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int CNT_W       = $clog2(DEF_MAX_WINDOW + 1)
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
    logic                   emit;
    logic [CNT_W-1:0]       center;
    logic [CNT_W-1:0]       half;
    logic [CNT_W-1:0]       limit;

    modport source (
        output valid, output sample, output last, output emit,
        output center, output half, output limit, input ready
    );
    modport sink (
        input valid, input sample, input last, input emit,
        input center, input half, input limit, output ready
    );
endinterface

>>> rtl/cmase_front.sv
module cmase_front
    import cmase_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    cmase_in_if.sink         samples,
    cmase_job_if.source      job
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    logic [CFG_W-1:0] window_size_reg;
    logic [CNT_W-1:0] rc_reg;
    logic [CNT_W-1:0] rc_next;
    logic [CNT_W-1:0] rc_new;
    logic [CNT_W-1:0] w_eff;
    logic [CNT_W-1:0] half;
    logic [CNT_W-1:0] limit;
    logic             accept;

    always_comb
    begin
        if (32'(window_size_reg) > 32'(MAX_WINDOW))
        begin
            w_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = CNT_W'(window_size_reg);
        end
        if (w_eff == '0)
        begin
            w_eff = CNT_W'(1);
        end
        half = (w_eff - CNT_W'(1)) >> 1;

        rc_new = (rc_reg < CNT_W'(MAX_WINDOW)) ? rc_reg + CNT_W'(1) : rc_reg;
        limit  = rc_new - CNT_W'(1);

        accept        = samples.valid && job.ready;
        samples.ready = job.ready;
        job.valid     = samples.valid;
        job.sample    = samples.range_sample;
        job.last      = samples.scan_end;
        job.emit      = samples.scan_end || (rc_new > half);
        job.half      = half;
        job.limit     = limit;
        if (samples.scan_end && (half > limit))
        begin
            job.center = limit;
        end
        else
        begin
            job.center = half;
        end

        rc_next = rc_reg;
        if (accept)
        begin
            rc_next = samples.scan_end ? '0 : rc_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
            rc_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_size_reg <= cfg_wdata;
            end
            rc_reg <= rc_next;
        end
    end

endmodule

>>> rtl/cmase_queue.sv
module cmase_queue
    import cmase_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    cmase_job_if.sink   wr,
    cmase_job_if.source rd
);

    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int ENTRY_W = SAMPLE_BITS + 2 + 3 * CNT_W;

    logic [ENTRY_W-1:0] slot_reg [2];
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;
    logic               wr_ptr_reg;
    logic               wr_ptr_next;
    logic               rd_ptr_reg;
    logic               rd_ptr_next;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               push;
    logic               pop;

    always_comb
    begin
        wr_entry = {wr.sample, wr.last, wr.emit, wr.center, wr.half, wr.limit};
        rd_entry = slot_reg[rd_ptr_reg];
        {rd.sample, rd.last, rd.emit, rd.center, rd.half, rd.limit} = rd_entry;

        wr.ready = (count_reg != 2'd2);
        rd.valid = (count_reg != 2'd0);
        push     = wr.valid && wr.ready;
        pop      = rd.valid && rd.ready;

        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/cmase_div.sv
module cmase_div #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  sh_reg;
    logic [NUM_W-1:0]  sh_next;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  den_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    always_comb
    begin
        trial = {rem_reg, sh_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});

        sh_next   = sh_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            sh_next   = dividend;
            rem_next  = '0;
            den_next  = divisor;
            step_next = STEP_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            sh_next   = {sh_reg[NUM_W-2:0], fits};
            rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

>>> rtl/cmase_back.sv
module cmase_back
    import cmase_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    cmase_job_if.sink   job,
    cmase_out_if.source smoothed
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W = SAMPLE_BITS + AGE_W;
    localparam int NUM_W = SUM_W + FRAC_BITS;
    localparam int OUT_W = SAMPLE_BITS + FRAC_BITS;

    back_state_t state_reg;
    back_state_t state_next;

    logic [SAMPLE_BITS-1:0] sample_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] mem_rdata_reg;
    logic                   mem_we;
    logic [AGE_W-1:0]       rd_addr;
    logic [CNT_W-1:0]       rd_age;
    logic [AGE_W:0]         addr_diff;

    logic [AGE_W-1:0] head_reg;
    logic [AGE_W-1:0] head_next;
    logic             flush_reg;
    logic             flush_next;
    logic [CNT_W-1:0] center_reg;
    logic [CNT_W-1:0] center_next;
    logic [CNT_W-1:0] half_reg;
    logic [CNT_W-1:0] half_next;
    logic [CNT_W-1:0] limit_reg;
    logic [CNT_W-1:0] limit_next;
    logic [CNT_W-1:0] top_reg;
    logic [CNT_W-1:0] top_next;
    logic [CNT_W-1:0] age_reg;
    logic [CNT_W-1:0] age_next;
    logic             pend_reg;
    logic             pend_next;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [OUT_W-1:0] out_value_reg;
    logic [OUT_W-1:0] out_value_next;
    logic             out_last_reg;
    logic             out_last_next;

    logic             div_start;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;
    logic [CNT_W-1:0] next_top;

    function automatic logic [CNT_W-1:0] clip_top(
        input logic [CNT_W-1:0] center,
        input logic [CNT_W-1:0] half,
        input logic [CNT_W-1:0] limit
    );
        logic [CNT_W:0] reach;
        reach = {1'b0, center} + {1'b0, half};
        if (reach > {1'b0, limit})
        begin
            return limit;
        end
        return reach[CNT_W-1:0];
    endfunction

    cmase_div #(
        .NUM_W (NUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_reg, {FRAC_BITS{1'b0}}}),
        .divisor  (top_reg + CNT_W'(1)),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        addr_diff = {1'b0, head_reg} - {1'b0, rd_age[AGE_W-1:0]};
        if (addr_diff[AGE_W])
        begin
            rd_addr = AGE_W'(addr_diff + (AGE_W + 1)'(MAX_WINDOW));
        end
        else
        begin
            rd_addr = addr_diff[AGE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[head_next] <= job.sample;
        end
        mem_rdata_reg <= sample_mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        flush_next     = flush_reg;
        center_next    = center_reg;
        half_next      = half_reg;
        limit_next     = limit_reg;
        top_next       = top_reg;
        age_next       = age_reg;
        pend_next      = pend_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !smoothed.ready;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        div_start      = 1'b0;
        rd_age         = age_reg;
        next_top       = clip_top(center_reg - CNT_W'(1), half_reg, limit_reg);
        job.ready      = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (job.valid)
                begin
                    mem_we      = 1'b1;
                    head_next   = (head_reg == AGE_W'(MAX_WINDOW - 1)) ? '0
                                                                      : head_reg + AGE_W'(1);
                    flush_next  = job.last;
                    center_next = job.center;
                    half_next   = job.half;
                    limit_next  = job.limit;
                    top_next    = clip_top(job.center, job.half, job.limit);
                    age_next    = '0;
                    sum_next    = '0;
                    pend_next   = 1'b0;
                    if (job.emit)
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                if (pend_reg)
                begin
                    sum_next = sum_reg + SUM_W'(mem_rdata_reg);
                end
                if (age_reg <= top_reg)
                begin
                    pend_next = 1'b1;
                    age_next  = age_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = ST_DIVGO;
                    end
                end
            end
            ST_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVWAIT;
            end
            ST_DIVWAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || smoothed.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = div_quot[OUT_W-1:0];
                    out_last_next  = flush_reg && (center_reg == '0);
                    if (flush_reg && (center_reg != '0))
                    begin
                        center_next = center_reg - CNT_W'(1);
                        pend_next   = 1'b0;
                        if (next_top != top_reg)
                        begin
                            state_next = ST_TRIM;
                        end
                        else
                        begin
                            state_next = ST_DIVGO;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TRIM:
            begin
                rd_age = top_reg;
                if (!pend_reg)
                begin
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    sum_next   = sum_reg - SUM_W'(mem_rdata_reg);
                    top_next   = top_reg - CNT_W'(1);
                    state_next = ST_DIVGO;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        center_reg    <= center_next;
        half_reg      <= half_next;
        limit_reg     <= limit_next;
        top_reg       <= top_next;
        age_reg       <= age_next;
        sum_reg       <= sum_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            flush_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            flush_reg     <= flush_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign smoothed.valid          = out_valid_reg;
    assign smoothed.smoothed_value = out_value_reg;
    assign smoothed.result_last    = out_last_reg;

endmodule

>>> rtl/centered_moving_average_shrink_edges_unit.sv
// A result is valid once its item has passed the queue and the back end has summed a window of
// top+1 samples from the sample memory, one read per cycle, then run the 29-step bit-serial
// divide and loaded the output register.
// Each further result of an end-of-scan flush runs another divide, after a trim step when the window shrinks.
// The back end takes one item at a time; an item that yields no result only stores its sample.
// Reset: rst_n clears all control state, the item count and the window size (back to 3).
module centered_moving_average_shrink_edges_unit
    import cmase_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    cmase_in_if.sink         samples,
    cmase_out_if.source      smoothed
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    cmase_job_if #(.SAMPLE_BITS(SAMPLE_BITS), .CNT_W(CNT_W)) job_in ();
    cmase_job_if #(.SAMPLE_BITS(SAMPLE_BITS), .CNT_W(CNT_W)) job_out ();

    cmase_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .samples   (samples),
        .job       (job_in)
    );

    cmase_queue #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (job_in),
        .rd    (job_out)
    );

    cmase_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job_out),
        .smoothed (smoothed)
    );

endmodule
